FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: hdl/bm25_pkg.sv
// Package with the types, constants and the logarithm table of the BM25 scorer.
package bm25_pkg;

  localparam int unsigned CountBits = 24;
  localparam int unsigned FreqBits  = 16;
  localparam int unsigned LogTableSize = 256;
  localparam int unsigned LogIdxBits = $clog2(LogTableSize);
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  // Configuration register indexes.
  localparam logic [1:0] RegDocCount = 2'd0;
  localparam logic [1:0] RegAvgLen   = 2'd1;
  localparam logic [1:0] RegK1       = 2'd2;
  localparam logic [1:0] RegB        = 2'd3;

  typedef struct packed {
    logic [FreqBits-1:0]  term_freq;
    logic [CountBits-1:0] doc_freq;
    logic [CountBits-1:0] doc_len;
    logic                 last_term;
  } term_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic               saturated;
  } result_t;

  typedef struct packed {
    logic [CountBits-1:0] doc_count;
    logic [39:0]          avg_doc_length;
    logic [15:0]          k1_gain;
    logic [16:0]          b_weight;
  } cfg_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OpLoad   = 4'd0,
    OpLnNum  = 4'd1,
    OpLnDen  = 4'd2,
    OpDivRat = 4'd3,
    OpLenMul = 4'd4,
    OpDenMul = 4'd5,
    OpDivTf  = 4'd6,
    OpTerm   = 4'd7,
    OpAccum  = 4'd8,
    OpTermHi = 4'd9,
    OpNone   = 4'd15
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
    logic div_step;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last;
  } dp_status_t;

  // One table entry ln(1+i/SIZE) in Q0.32, via the atanh series.
  function automatic logic [33:0] ln_entry(input int unsigned i);
    logic [63:0] z, z2, pw, acc;
    z   = (64'(i) << 32) / 64'(2 * LogTableSize + i);
    z2  = (z * z) >> 32;
    pw  = z;
    acc = '0;
    for (int k = 0; k < 16; k++) begin
      acc = acc + pw / 64'(2 * k + 1);
      pw  = (pw * z2) >> 32;
    end
    return 34'(2 * acc);
  endfunction

  typedef logic [33:0] ln_rom_t [LogTableSize+1];

  function automatic ln_rom_t build_ln_rom();
    ln_rom_t r;
    for (int unsigned i = 0; i <= LogTableSize; i++) begin
      r[i] = ln_entry(i);
    end
    return r;
  endfunction

  localparam ln_rom_t LnRom = build_ln_rom();

endpackage

FILE: hdl/bm25_if.sv
// Valid/ready stream interface carrying one payload.
interface bm25_if #(parameter type payload_t = logic) (input logic clk_i);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/bm25_ctrl.sv
// Controller state machine sequencing one term through the datapath.
module bm25_ctrl import bm25_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StLnNum = 10'b0000000010,
    StLnDen = 10'b0000000100,
    StDivR  = 10'b0000001000,
    StLenM  = 10'b0000010000,
    StDenM  = 10'b0000100000,
    StDivT  = 10'b0001000000,
    StTerm  = 10'b0010000000,
    StTermH = 10'b0100000000,
    StAcc   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // The next item may enter once the result register can take its outcome.
  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{op: OpNone, start: 1'b0, div_step: 1'b0, clear: 1'b0};
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.op = OpLoad;
          state_d  = StLnNum;
        end
      end
      StLnNum: begin
        cmd_o.op = OpLnNum;
        state_d  = StLnDen;
      end
      StLnDen: begin
        cmd_o.op    = OpLnDen;
        cmd_o.start = 1'b1;
        state_d     = StDivR;
      end
      StDivR: begin
        cmd_o.op       = OpDivRat;
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = StLenM;
        end
      end
      StLenM: begin
        cmd_o.op = OpLenMul;
        state_d  = StDenM;
      end
      StDenM: begin
        cmd_o.op    = OpDenMul;
        cmd_o.start = 1'b1;
        state_d     = StDivT;
      end
      StDivT: begin
        cmd_o.op       = OpDivTf;
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = StTerm;
        end
      end
      StTerm: begin
        cmd_o.op = OpTerm;
        state_d  = StTermH;
      end
      StTermH: begin
        cmd_o.op = OpTermHi;
        state_d  = StAcc;
      end
      StAcc: begin
        cmd_o.op    = OpAccum;
        cmd_o.clear = status_i.last;
        out_valid_d = status_i.last;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/bm25_dp.sv
// Datapath: logarithm unit, shared restoring divider, multipliers, accumulator.
module bm25_dp import bm25_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  term_t      term_i,
  input  cfg_t       cfg_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output result_t    result_o
);

  logic [FreqBits-1:0]  tf_q;
  logic [CountBits-1:0] df_q, len_q;
  logic                 last_q;
  logic [39:0]          ln_num_q;
  logic [39:0]          idf_q;
  logic                 neg_q;
  logic [40:0]          l_q;
  logic [49:0]          den_q;
  logic [63:0]          tprod_q;
  logic [63:0]          mag_q;
  logic signed [39:0]   sum_q;
  logic                 ovf_q;

  // Shared restoring divider: 64-bit dividend, 50-bit divisor, one bit per cycle.
  logic [63:0] dq_q;
  logic [50:0] drem_q;
  logic [49:0] dvs_q;
  logic [6:0]  dcnt_q;
  logic [50:0] trial;
  logic        dsub;
  assign trial = {drem_q[49:0], dq_q[63]};
  assign dsub  = trial >= {1'b0, dvs_q};
  assign status_o.div_done = (dcnt_q == 7'd1);
  assign status_o.last     = last_q;

  // Clamped configuration values.
  logic [CountBits-1:0] df_c;
  logic [39:0]          avg_c;
  logic [16:0]          b_c;
  assign df_c  = (term_i.doc_freq > cfg_i.doc_count) ? cfg_i.doc_count : term_i.doc_freq;
  assign avg_c = (cfg_i.avg_doc_length < 40'd65536) ? 40'd65536 : cfg_i.avg_doc_length;
  assign b_c   = (cfg_i.b_weight > 17'd65536) ? 17'd65536 : cfg_i.b_weight;

  // Logarithm of a 26-bit integer: leading one, table lookup and interpolation.
  logic [25:0] ln_x;
  logic [4:0]  ln_e;
  logic [31:0] ln_frac;
  logic [LogIdxBits-1:0] ln_idx;
  logic [LogIdxBits:0]   ln_idx_hi;
  logic [31:0] ln_rem;
  logic [33:0] ln_lo, ln_hi;
  logic [65:0] ln_prod;
  logic [39:0] ln_val;
  assign ln_x = (cmd_i.op == OpLnNum)
      ? 26'({1'b0, cfg_i.doc_count - df_q, 1'b1}) : 26'({1'b0, df_q, 1'b1});
  always_comb begin
    ln_e = '0;
    for (int i = 0; i < 26; i++) begin
      if (ln_x[i]) ln_e = 5'(i);
    end
  end
  assign ln_frac   = 32'({ln_x, 32'd0} >> ln_e);
  assign ln_idx    = ln_frac[31 -: LogIdxBits];
  assign ln_idx_hi = {1'b0, ln_idx} + (LogIdxBits+1)'(1);
  assign ln_rem    = 32'({ln_frac, LogIdxBits'(0)});
  assign ln_lo     = LnRom[{1'b0, ln_idx}];
  assign ln_hi     = (LnRom[ln_idx_hi] < ln_lo) ? ln_lo : LnRom[ln_idx_hi];
  assign ln_prod   = 66'(ln_hi - ln_lo) * 66'(ln_rem);
  assign ln_val    = 40'(ln_e) * 40'(Ln2Q32) + 40'(ln_lo) + 40'(ln_prod >> 32);

  // Term-level arithmetic: length factor, denominator, numerator and idf product.
  logic [57:0] lmul;
  logic [40:0] l_next;
  logic [49:0] den_next;
  logic [32:0] num;
  logic [31:0] tmul_b;
  logic [68:0] tmul;
  logic [63:0] tsum;
  logic [63:0] mag_n;
  logic signed [40:0] sum_n;
  assign lmul     = 58'(b_c) * 58'(dq_q[39:0]);
  assign l_next   = 41'(((58'(17'd65536 - b_c) << 16) + lmul + 58'd32768) >> 16);
  assign den_next = 50'((58'(tf_q) << 16)
                        + ((58'(cfg_i.k1_gain) * 58'(l_q) + 58'd128) >> 8));
  assign num      = 33'(tf_q) * (33'(cfg_i.k1_gain) + 33'd256);
  // The idf times tf product is formed modulo 2^64 from two 32-bit halves.
  assign tmul_b   = (cmd_i.op == OpTerm) ? dq_q[31:0] : dq_q[63:32];
  assign tmul     = 69'(idf_q[36:0]) * 69'(tmul_b);
  assign tsum     = tprod_q + {tmul[31:0], 32'd0} + 64'h8000_0000;
  assign mag_n    = {32'd0, tsum[63:32]};
  assign sum_n    = 41'(sum_q) + (neg_q ? -41'(mag_q) : 41'(mag_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      ovf_q  <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.div_step && dcnt_q != 7'd0) begin
        dcnt_q <= dcnt_q - 7'd1;
      end
      unique case (cmd_i.op)
        OpLnDen: dcnt_q <= 7'd64;
        OpDenMul: dcnt_q <= 7'd64;
        OpTermHi: begin
          if (den_q != '0 && mag_n > 64'h7FFFFFFF) ovf_q <= 1'b1;
        end
        OpAccum: begin
          if (cmd_i.clear) begin
            sum_q <= '0;
            ovf_q <= 1'b0;
          end else if (sum_n > 41'sh7FFFFFFF) begin
            sum_q <= 40'sh7FFFFFFF;
            ovf_q <= 1'b1;
          end else if (sum_n < -41'sh80000000) begin
            sum_q <= -40'sh80000000;
            ovf_q <= 1'b1;
          end else begin
            sum_q <= 40'(sum_n);
          end
        end
        default: ;
      endcase
    end
  end

  // Result as it stands after the final accumulate.
  logic signed [39:0] fin;
  logic               fin_ovf;
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpAccum && cmd_i.clear) begin
      result_o.score     <= 32'(fin);
      result_o.saturated <= fin_ovf;
    end
  end
  always_comb begin
    fin     = 40'(sum_n);
    fin_ovf = ovf_q;
    if (sum_n > 41'sh7FFFFFFF) begin
      fin = 40'sh7FFFFFFF;
      fin_ovf = 1'b1;
    end else if (sum_n < -41'sh80000000) begin
      fin = -40'sh80000000;
      fin_ovf = 1'b1;
    end
  end

  // Payload registers for operands and the divider.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpLoad: begin
        tf_q   <= term_i.term_freq;
        df_q   <= df_c;
        len_q  <= term_i.doc_len;
        last_q <= term_i.last_term;
      end
      OpLnNum: ln_num_q <= ln_val;
      OpLnDen: begin
        neg_q  <= ln_num_q < ln_val;
        idf_q  <= (ln_num_q < ln_val) ? ln_val - ln_num_q : ln_num_q - ln_val;
        dq_q   <= {8'd0, len_q, 32'd0};
        drem_q <= '0;
        dvs_q  <= 50'(avg_c);
      end
      OpLenMul: l_q <= l_next;
      OpDenMul: begin
        den_q  <= den_next;
        dq_q   <= {7'd0, num, 24'd0};
        drem_q <= '0;
        dvs_q  <= den_next;
      end
      OpTerm: tprod_q <= tmul[63:0];
      // A zero denominator yields a zero quotient.
      OpTermHi: mag_q <= (den_q == '0) ? 64'd0
                         : (mag_n > 64'h7FFFFFFF) ? 64'h7FFFFFFF : mag_n;
      default: ;
    endcase
    if (cmd_i.div_step && dcnt_q != 7'd0) begin
      drem_q <= dsub ? trial - {1'b0, dvs_q} : trial;
      dq_q   <= {dq_q[62:0], dsub};
    end
  end

endmodule

FILE: hdl/bm25_relevance_scorer.sv
// Top level of the BM25 relevance scorer: APB registers, controller, datapath.
// A term is taken in the idle state and then occupies the block through
// the two table logarithms, 64 steps of the one shared restoring divider
// for the length ratio, one length multiply, the denominator step, 64
// divider steps for the term-frequency part, the two halves of the idf
// product and one accumulate; no new term is taken before that
// accumulate. A result transfer occurs only for a term marked last; the
// next term is taken once that result has left the output register.
// Registers: doc_count at 0x0, avg_doc_length at 0x8, k1_gain at 0x10,
// b_weight at 0x18, 64-bit data.
module bm25_relevance_scorer import bm25_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bm25_if.sink        in_if,
  bm25_if.source      out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  // Register file writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{doc_count: 24'd1, avg_doc_length: 40'd65536,
                 k1_gain: 16'd512, b_weight: 17'd49152};
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDocCount: cfg_q.doc_count      <= pwdata[CountBits-1:0];
        RegAvgLen:   cfg_q.avg_doc_length <= pwdata[39:0];
        RegK1:       cfg_q.k1_gain        <= pwdata[15:0];
        RegB:        cfg_q.b_weight       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegDocCount: prdata = 64'(cfg_q.doc_count);
      RegAvgLen:   prdata = 64'(cfg_q.avg_doc_length);
      RegK1:       prdata = 64'(cfg_q.k1_gain);
      RegB:        prdata = 64'(cfg_q.b_weight);
      default: ;
    endcase
  end

  bm25_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bm25_dp u_dp (
    .clk_i, .rst_ni,
    .term_i  (in_if.data),
    .cfg_i   (cfg_q),
    .cmd_i   (cmd),
    .status_o(status),
    .result_o(result)
  );

  assign out_if.data = result;

endmodule

FILE: hdl/bm25_checker.sv
// Port-level checker for the BM25 scorer, bound to the top level.
`include "assert_macros.svh"
module bm25_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pready
);
  `ASSERT_IMPL(a_pready_high, clk_i, rst_ni, 1'b1, pready, "pready must stay high")
  `ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_IMPL(a_no_take_busy, clk_i, rst_ni, out_valid, !in_ready, "input taken with result pending")
  `ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid && in_ready, !in_ready, "second term taken while busy")
endmodule

bind bm25_relevance_scorer bm25_checker u_checker (
  .clk_i, .rst_ni,
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .pready
);

FILE: verif/testbench.sv
// Self-checking testbench of the BM25 relevance scorer with a term score predictor.
module testbench;
  import bm25_pkg::*;

  // Predicts the summed BM25 scores and holds the scores still to arrive.
  class score_board;
    logic [63:0] ln_tab [LogTableSize+1];
    logic [63:0] n_docs, avg_len, k1, b_w;
    longint      run_sum;
    bit          sat_seen;
    result_t     pending [$];
    int          errors;

    function new();
      logic [63:0] z, z2, pw, acc;
      for (int i = 0; i <= LogTableSize; i++) begin
        z   = (64'(i) << 32) / 64'(2 * LogTableSize + i);
        z2  = (z * z) >> 32;
        pw  = z;
        acc = '0;
        for (int k = 0; k < 16; k++) begin
          acc = acc + pw / 64'(2 * k + 1);
          pw  = (pw * z2) >> 32;
        end
        ln_tab[i] = 2 * acc;
      end
      n_docs   = 1;
      avg_len  = 65536;
      k1       = 512;
      b_w      = 49152;
      run_sum  = 0;
      sat_seen = 0;
      errors   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        RegDocCount: n_docs  = val[CountBits-1:0];
        RegAvgLen:   avg_len = val[39:0];
        RegK1:       k1      = val[15:0];
        RegB:        b_w     = val[16:0];
        default: ;
      endcase
    endfunction

    // Natural log in Q.32 by table interpolation on the mantissa.
    function logic [63:0] ln_fixed(logic [63:0] x);
      int unsigned e;
      logic [63:0] norm, frac, scaled, idx, rem, lo, hi;
      e = 0;
      if (x == 0) x = 1;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      norm   = (e <= 32) ? (x << (32 - e)) : (x >> (e - 32));
      frac   = norm & 64'hFFFF_FFFF;
      scaled = frac * LogTableSize;
      idx    = scaled >> 32;
      rem    = scaled & 64'hFFFF_FFFF;
      if (idx >= LogTableSize) idx = LogTableSize - 1;
      lo = ln_tab[idx];
      hi = ln_tab[idx + 1];
      if (hi < lo) hi = lo;
      return 64'(e) * 64'(Ln2Q32) + lo + (((hi - lo) * rem) >> 32);
    endfunction

    // Adds the score of one accepted term and notes the sum on a last term.
    function void note_term(term_t t);
      logic [63:0] tf, df, len, avg, b, lnn, lnd, idf, ratio, lq, den, num, tfp, mag;
      bit          neg;
      longint      term;
      result_t     r;
      tf  = t.term_freq;
      df  = t.doc_freq;
      len = t.doc_len;
      avg = (avg_len < 65536) ? 64'd65536 : avg_len;
      b   = (b_w > 65536) ? 64'd65536 : b_w;
      if (df > n_docs) df = n_docs;
      lnn = ln_fixed(2 * (n_docs - df) + 1);
      lnd = ln_fixed(2 * df + 1);
      neg = lnn < lnd;
      idf = neg ? lnd - lnn : lnn - lnd;
      ratio = (len << 32) / avg;
      lq    = (((64'd65536 - b) << 16) + b * ratio + 64'd32768) >> 16;
      den   = (tf << 16) + ((k1 * lq + 64'd128) >> 8);
      num   = tf * (k1 + 64'd256);
      tfp   = (den == 0) ? 64'd0 : (num << 24) / den;
      mag   = (idf * tfp + 64'h8000_0000) >> 32;
      if (mag > 64'h7FFF_FFFF) begin
        mag      = 64'h7FFF_FFFF;
        sat_seen = 1;
      end
      term = neg ? -longint'(mag) : longint'(mag);
      run_sum += term;
      if (run_sum > 64'sh7FFF_FFFF) begin
        run_sum  = 64'sh7FFF_FFFF;
        sat_seen = 1;
      end else if (run_sum < -64'sh8000_0000) begin
        run_sum  = -64'sh8000_0000;
        sat_seen = 1;
      end
      if (t.last_term) begin
        r.score     = run_sum[31:0];
        r.saturated = sat_seen;
        pending     = {pending, r};
        run_sum  = 0;
        sat_seen = 0;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected score, expected none, actual %0d/%0b",
                 $time, got.score, got.saturated);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.score !== want.score) begin
        $display("%0t: score expected %0d actual %0d", $time, want.score, got.score);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [63:0] pwdata, prdata;
  int          idle_pct, stall_pct, hold_req, hold_cnt;
  score_board  sb;

  bm25_if #(.payload_t(term_t))   in_if  (clk_i);
  bm25_if #(.payload_t(result_t)) out_if (clk_i);

  bm25_relevance_scorer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Every result transfer is checked against the oldest predicted score.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  task automatic apb_write(logic [1:0] idx, logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until no score is outstanding and the block has settled, then configures.
  task automatic configure(logic [63:0] n, logic [63:0] avg, logic [63:0] k1v,
                           logic [63:0] bv);
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    apb_write(RegDocCount, n);
    apb_write(RegAvgLen, avg);
    apb_write(RegK1, k1v);
    apb_write(RegB, bv);
  endtask

  // Offers one term after random idle cycles and holds it until its transfer.
  task automatic send_term(term_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_term(t);
  endtask

  task automatic send_fields(int tf, int df, int len, bit last);
    term_t t;
    t.term_freq  = tf[FreqBits-1:0];
    t.doc_freq   = df[CountBits-1:0];
    t.doc_len    = len[CountBits-1:0];
    t.last_term  = last;
    send_term(t);
  endtask

  function automatic term_t random_term(bit force_last);
    term_t       t;
    int unsigned n;
    n = 32'(sb.n_docs);
    case ($urandom_range(3))
      0: t.term_freq = 16'($urandom_range(8));
      1: t.term_freq = 16'($urandom);
      2: t.term_freq = 16'($urandom_range(255));
      default: t.term_freq = $urandom_range(1) ? 16'hFFFF : 16'h0;
    endcase
    case ($urandom_range(4))
      0: t.doc_freq = 24'($urandom);
      1: t.doc_freq = 24'(n);
      2: t.doc_freq = '0;
      default: t.doc_freq = 24'($urandom_range(n, 0));
    endcase
    t.doc_len    = $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(2000));
    t.last_term  = force_last || ($urandom_range(3) == 0);
    return t;
  endfunction

  function automatic logic [63:0] pick(logic [63:0] lo, logic [63:0] hi,
                                       logic [63:0] rnd);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return rnd;
    endcase
  endfunction

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [63:0] n, avg, k1v, bv;
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and clamping of df above N.
    configure(1000, 100 << 16, 512, 49152);
    send_fields(0, 10, 100, 0);
    send_fields(65535, 10, 100, 1);
    send_fields(3, 0, 0, 0);
    send_fields(3, 1000, 24'hFFFFFF, 1);
    send_fields(3, 24'hFFFFFF, 50, 1);
    send_fields(1, 500, 100, 1);

    // Zero denominator with k1 of zero and no occurrences, then a zero length.
    configure(1000, 100 << 16, 0, 0);
    send_fields(0, 5, 100, 1);
    send_fields(7, 5, 0, 1);

    // Sum saturation both ways; avg below one word and b above one.
    configure(24'hFFFFFF, 0, 16'hFFFF, 17'h1FFFF);
    for (int i = 0; i < 9; i++) send_fields(1, 0, 0, i == 8);
    for (int i = 0; i < 9; i++) send_fields(1, 24'hFFFFFF, 0, i == 8);

    // N of zero.
    configure(0, 40'hFF_FFFF_FFFF, 256, 65536);
    send_fields(9, 4, 1234, 1);

    // Random phases under varying registers and flow control.
    for (int ph = 0; ph < 8; ph++) begin
      n   = pick(1, 24'hFFFFFF, 64'($urandom_range(5000, 1)));
      avg = pick(65536, 40'hFF_FFFF_FFFF, 64'($urandom_range(3000, 1)) << 16);
      k1v = pick(0, 16'hFFFF, 64'($urandom_range(1024)));
      bv  = pick(0, 65536, 64'($urandom_range(65536)));
      configure(n, avg, k1v, bv);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (ph == 4) begin
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 3000;
      end
      for (int i = 0; i < 160; i++) send_term(random_term(i == 159));
      if (ph % 4 == 3) begin
        idle_pct = 0;
        stall_pct = 0;
      end
    end

    // Drain and report.
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+hdl
hdl/bm25_pkg.sv
hdl/bm25_if.sv
hdl/bm25_ctrl.sv
hdl/bm25_dp.sv
hdl/bm25_relevance_scorer.sv
hdl/bm25_checker.sv
verif/testbench.sv
